// File: sv/lru_key_value_cache_unit_assert.svh
// Assertion macros used by the LRU key-value cache datapath
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define LKV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lkv check failed");

// Condition in one cycle implies a consequence in the next cycle
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkv sequence check failed");

`endif

// File: sv/lkv_pkg.sv
// Shared constants, a command type and a helper function of the LRU key-value cache
package lkv_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CountW     = $clog2(MaxEntries + 1);
  localparam int CfgW       = 5;
  localparam int KeyW       = 32;
  localparam int ValW       = 32;

  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  localparam logic signed [ValW-1:0] MissValue = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } lkv_cmd_t;

  // Lowest set position of a vector; zero when nothing is set
  function automatic logic [IdxW-1:0] first_set_idx(input logic [MaxEntries-1:0] vec);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: sv/lkv_ram.sv
// Generic single-write, single-read RAM with registered read data
module lkv_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lkv_ctrl.sv
// Sequencer of the LRU cache: capture, lookup, commit
module lkv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output lkv_pkg::lkv_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StLookup = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLookup;
        end
      end
      StLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// File: sv/lkv_datapath.sv
// Key compare, recency ranks, entry stores and result register of the LRU cache
`include "lru_key_value_cache_unit_assert.svh"

module lkv_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkv_pkg::lkv_cmd_t                 cmd_i,
  input  logic                              cfg_we_i,
  input  logic [lkv_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              op_i,
  input  logic signed [lkv_pkg::KeyW-1:0]   key_i,
  input  logic signed [lkv_pkg::ValW-1:0]   value_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic signed [lkv_pkg::ValW-1:0]   read_value_o,
  output logic                              evicted_o
);

  localparam int N = lkv_pkg::MaxEntries;

  // Configuration
  logic [lkv_pkg::CfgW-1:0]   capacity_q;
  logic [lkv_pkg::CountW-1:0] eff_cap;

  // Captured request word
  logic                     op_q;
  logic [lkv_pkg::KeyW-1:0] key_q;
  logic [lkv_pkg::ValW-1:0] value_q;

  // Entry state
  logic [N-1:0]             valid_q, valid_d;
  logic [lkv_pkg::IdxW-1:0] rank_q [N];
  logic [lkv_pkg::IdxW-1:0] rank_d [N];
  logic [lkv_pkg::KeyW-1:0] key_store_q [N];
  logic [lkv_pkg::CountW-1:0] count_q, count_d;

  // Lookup results
  logic [N-1:0]             match_vec, oldest_vec;
  logic                     any_hit, full;
  logic [lkv_pkg::IdxW-1:0] hit_idx, victim_idx;
  logic [lkv_pkg::IdxW-1:0] oldest_rank;
  logic [lkv_pkg::CountW-1:0] count_m1;
  logic                     hit_q, evict_q;
  logic [lkv_pkg::IdxW-1:0] slot_q;
  logic [lkv_pkg::IdxW-1:0] slot_rank;
  logic                     is_put, insert;

  // Results
  logic                     done_q, hit_out_q, evicted_q;
  logic [lkv_pkg::ValW-1:0] read_value_q;
  logic [lkv_pkg::ValW-1:0] ram_rdata;
  logic                     ram_we;

  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = lkv_pkg::CountW'(1);
    end else if (int'(capacity_q) > N) begin
      eff_cap = lkv_pkg::CountW'(N);
    end else begin
      eff_cap = lkv_pkg::CountW'(capacity_q);
    end
  end

  // Ranks of valid entries form a permutation of 0 .. count-1, so the oldest
  // entry is the one whose rank equals count-1
  assign count_m1    = lkv_pkg::CountW'(count_q - 1'b1);
  assign oldest_rank = count_m1[lkv_pkg::IdxW-1:0];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = valid_q[i] && (key_store_q[i] == key_q);
      oldest_vec[i] = valid_q[i] && (rank_q[i] == oldest_rank);
    end
  end

  assign any_hit    = |match_vec;
  assign hit_idx    = lkv_pkg::first_set_idx(match_vec);
  assign full       = (count_q >= eff_cap);
  assign victim_idx = full ? lkv_pkg::first_set_idx(oldest_vec)
                           : lkv_pkg::first_set_idx(~valid_q);

  assign is_put    = (op_q == lkv_pkg::CmdPut);
  assign insert    = is_put && !hit_q;
  assign slot_rank = rank_q[slot_q];

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.commit) begin
      if (hit_q) begin
        // Promote: entries younger than the hit one age by one
        for (int i = 0; i < N; i++) begin
          if ((lkv_pkg::IdxW'(i) != slot_q) && valid_q[i] && (rank_q[i] < slot_rank)) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[slot_q] = '0;
      end else if (insert) begin
        // Every other valid entry ages; an evicted slot is reused in place
        for (int i = 0; i < N; i++) begin
          if ((lkv_pkg::IdxW'(i) != slot_q) && valid_q[i]) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[slot_q]  = '0;
        valid_d[slot_q] = 1'b1;
        if (!evict_q) begin
          count_d = lkv_pkg::CountW'(count_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lkv_pkg::CfgW'(N);
      valid_q    <= '0;
      count_q    <= '0;
      done_q     <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
      count_q <= count_d;
      done_q  <= cmd_i.commit;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.lookup) begin
      hit_q   <= any_hit;
      slot_q  <= any_hit ? hit_idx : victim_idx;
      evict_q <= (op_q == lkv_pkg::CmdPut) && !any_hit && full;
    end
    if (cmd_i.commit && insert) begin
      key_store_q[slot_q] <= key_q;
    end
    if (cmd_i.commit) begin
      hit_out_q <= hit_q;
      evicted_q <= evict_q && insert;
      if (is_put) begin
        read_value_q <= '0;
      end else if (hit_q) begin
        read_value_q <= ram_rdata;
      end else begin
        read_value_q <= lkv_pkg::MissValue;
      end
    end
  end

  assign ram_we = cmd_i.commit && is_put;

  lkv_ram #(
    .Width(lkv_pkg::ValW),
    .Depth(N)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(value_q),
    .raddr_i(hit_idx),
    .rdata_o(ram_rdata)
  );

  assign done_o       = done_q;
  assign hit_o        = hit_out_q;
  assign read_value_o = read_value_q;
  assign evicted_o    = evicted_q;

  `LKV_ASSERT(a_count_matches_valid, clk_i, rst_ni,
              $countones(valid_q) == int'(count_q))
  `LKV_ASSERT(a_evict_only_when_full, clk_i, rst_ni,
              !(cmd_i.commit && evict_q && insert) || (count_q >= eff_cap))
  `LKV_ASSERT(a_evict_is_miss, clk_i, rst_ni,
              !(done_q && evicted_q) || (!hit_out_q && (read_value_q == '0)))
  `LKV_ASSERT_NEXT(a_commit_strobes, clk_i, rst_ni, cmd_i.commit, done_q)

endmodule

// File: sv/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: controller plus datapath
// Usage:
//   Request channel: drive cmd_i (0 get, 1 put), key_i and value_i with
//   start_i high; the word is taken at a rising edge where busy_o is low.
//   Result channel: done_o is high for exactly one cycle with hit_o,
//   read_value_o and evicted_o; the receiver cannot stall it and must take
//   the word in that cycle.
//   Capacity register: cfg_we_i high writes cfg_wdata_i; write only while
//   no request is in flight. 0 acts as 1, values above 16 act as 16.
// Sequence:
//   A busy request passes through the lookup state, for the parallel key
//   compare across all 16 entries with the value RAM read, then the commit
//   state, for the recency and store update. done_o follows in the cycle
//   after commit, and a new request may be accepted in that cycle. A new
//   request is not taken while busy_o is high, so requests do not overlap.
// Reset:
//   rst_ni clears all valid marks, ranks and the entry count, and sets the
//   capacity to 16. Key and value stores are not cleared.
module lru_key_value_cache_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cmd_i,
  input  logic signed [lkv_pkg::KeyW-1:0]   key_i,
  input  logic signed [lkv_pkg::ValW-1:0]   value_i,
  input  logic                              cfg_we_i,
  input  logic [lkv_pkg::CfgW-1:0]          cfg_wdata_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic signed [lkv_pkg::ValW-1:0]   read_value_o,
  output logic                              evicted_o
);

  lkv_pkg::lkv_cmd_t ctrl_cmd;

  lkv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (ctrl_cmd)
  );

  lkv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (cmd_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .read_value_o(read_value_o),
    .evicted_o   (evicted_o)
  );

endmodule
